FILE: rtl/ncl_pkg.sv
// Shared types and constants for the nearest-centroid label block.
package ncl_pkg;

  // Fixed field widths of the word formats.
  localparam int unsigned FEATURES  = 4;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned SQ_W      = 2 * COORD_W;
  localparam int unsigned DIST_W    = SQ_W + $clog2(FEATURES);
  localparam int unsigned LABEL_W   = 6;
  localparam int unsigned EIDX_W    = 6;
  localparam int unsigned ACTIVE_W  = 7;

  // Operation codes carried in the opcode field.
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [FEATURES-1:0] point_t;

  // Input word: a centroid load or a point to classify.
  typedef struct packed {
    logic                opcode;
    logic [EIDX_W-1:0]   entry_index;
    logic [LABEL_W-1:0]  entry_label;
    logic signed [COORD_W-1:0] coord_0;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_3;
  } in_word_t;

  // Result word of one classify.
  typedef struct packed {
    logic [LABEL_W-1:0] cluster_label;
    logic [EIDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0]  min_distance;
  } out_word_t;

  // One table entry as held in a lane memory.
  typedef struct packed {
    logic [LABEL_W-1:0] label;
    point_t             point;
  } entry_t;

  // Control tag that travels beside each row through the lanes.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } scan_tag_t;

endpackage

FILE: rtl/ncl_lane.sv
// One distance lane: a bank of the centroid table and a squared-distance pipeline.
module ncl_lane
  import ncl_pkg::*;
#(
  parameter int unsigned ROWS  = 16,
  parameter int unsigned ROW_W = 4
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [ROW_W-1:0]   wr_row_i,
  input  entry_t             wr_entry_i,
  input  logic               rd_en_i,
  input  logic [ROW_W-1:0]   rd_row_i,
  input  point_t             point_i,
  output logic [DIST_W-1:0]  dist_o,
  output logic [LABEL_W-1:0] label_o
);

  entry_t mem [ROWS];

  entry_t             rd_q;
  logic [SQ_W-1:0]    sq_q [FEATURES];
  logic [SQ_W-1:0]    sq_d [FEATURES];
  logic [LABEL_W-1:0] label2_q;
  logic [DIST_W-1:0]  dist_q, dist_d;
  logic [LABEL_W-1:0] label3_q;

  // Bank storage: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_row_i];
    end
  end

  // Per-feature difference and square, one multiplier per feature.
  always_comb begin
    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] prod;
    for (int f = 0; f < FEATURES; f++) begin
      diff    = DIFF_W'(point_i[f]) - DIFF_W'(rd_q.point[f]);
      prod    = diff * diff;
      sq_d[f] = SQ_W'(unsigned'(prod));
    end
  end

  // Sum of the squared differences.
  always_comb begin
    dist_d = '0;
    for (int f = 0; f < FEATURES; f++) begin
      dist_d = dist_d + DIST_W'(sq_q[f]);
    end
  end

  // Square and sum stages.
  always_ff @(posedge clk_i) begin
    sq_q     <= sq_d;
    label2_q <= rd_q.label;
    dist_q   <= dist_d;
    label3_q <= label2_q;
  end

  assign dist_o  = dist_q;
  assign label_o = label3_q;

endmodule

FILE: rtl/ncl_merge.sv
// Merge stage: picks the nearest lane of a row, then keeps the running best of the scan.
module ncl_merge
  import ncl_pkg::*;
#(
  parameter int unsigned LANES = 4,
  parameter int unsigned ROW_W = 4,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned CNT_W = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scan_tag_t          tag_i,
  input  logic [ROW_W-1:0]   row_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic [DIST_W-1:0]  dist_i [LANES],
  input  logic [LABEL_W-1:0] label_i [LANES],
  output out_word_t          best_o,
  output logic               done_o
);

  logic [DIST_W-1:0]  cand_dist_d, cand_dist_q;
  logic [IDX_W-1:0]   cand_idx_d, cand_idx_q;
  logic [LABEL_W-1:0] cand_label_d, cand_label_q;
  scan_tag_t          cand_tag_q;

  logic [DIST_W-1:0]  acc_dist_q;
  logic [IDX_W-1:0]   acc_idx_q;
  logic [LABEL_W-1:0] acc_label_q;
  logic               done_q;

  // Row winner; lane zero of a scanned row is always in range, lower lanes win ties.
  always_comb begin
    int base;
    base         = int'(row_i) * LANES;
    cand_dist_d  = dist_i[0];
    cand_idx_d   = IDX_W'(base);
    cand_label_d = label_i[0];
    for (int l = 1; l < LANES; l++) begin
      if ((base + l < int'(count_i)) && (dist_i[l] < cand_dist_d)) begin
        cand_dist_d  = dist_i[l];
        cand_idx_d   = IDX_W'(base + l);
        cand_label_d = label_i[l];
      end
    end
  end

  // Row winner register.
  always_ff @(posedge clk_i) begin
    cand_dist_q  <= cand_dist_d;
    cand_idx_q   <= cand_idx_d;
    cand_label_q <= cand_label_d;
  end

  // Running best; earlier rows win ties by the strict compare.
  always_ff @(posedge clk_i) begin
    if (cand_tag_q.valid && (cand_tag_q.first || (cand_dist_q < acc_dist_q))) begin
      acc_dist_q  <= cand_dist_q;
      acc_idx_q   <= cand_idx_q;
      acc_label_q <= cand_label_q;
    end
  end

  // Tag and completion flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_tag_q <= '0;
      done_q     <= 1'b0;
    end else begin
      cand_tag_q <= tag_i;
      done_q     <= cand_tag_q.valid && cand_tag_q.last;
    end
  end

  assign best_o.cluster_label = acc_label_q;
  assign best_o.nearest_index = EIDX_W'(acc_idx_q);
  assign best_o.min_distance  = acc_dist_q;
  assign done_o               = done_q;

endmodule

FILE: rtl/nearest_centroid_label.sv
// Top level of the nearest-centroid classifier with squared Euclidean distance.
//
// Input words arrive on in_valid_i/in_ready_o. A load word writes one centroid and
// its label into the table slot entry_index and produces no result; loads are taken
// one per cycle while idle. A classify word carries a point; the block scans the first
// active_centroids entries, LANES entries per cycle, one row of every lane bank a
// cycle, and returns the label, index and squared distance of the nearest entry
// (lowest index on ties) as one word on out_valid_o/out_ready_i.
// A classify scans R = ceil(active_centroids / LANES) rows through the one read port
// of each lane bank; the result word becomes valid as the block returns to idle, and
// the next word is accepted in that same cycle. With the defaults R is at most 16.
// The output register holds a finished word while the receiver stalls; input words
// are still accepted then, and a later classify waits before its result only until
// the held word is taken.
// cfg_we_i writes active_centroids from cfg_data_i; a count of zero is searched as
// one, a count above MAX_CENTROIDS as MAX_CENTROIDS. Write it only while idle.
// Reset clears the control logic and sets active_centroids to one; the table has
// no reset and an entry must be loaded before a classify searches it.
module nearest_centroid_label
  import ncl_pkg::*;
#(
  parameter int unsigned MAX_CENTROIDS = 64,
  parameter int unsigned LANES         = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ACTIVE_W-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o
);

  localparam int unsigned ROWS  = MAX_CENTROIDS / LANES;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned IDX_W = $clog2(MAX_CENTROIDS);
  localparam int unsigned CNT_W = $clog2(MAX_CENTROIDS + 1);
  localparam int unsigned CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
  localparam int unsigned PIPE  = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [ACTIVE_W-1:0] active_q;
  logic [ROW_W-1:0]    row_q, last_row_q;
  logic [CNT_W-1:0]    count_q, count_d;
  point_t              point_q, in_point;
  out_word_t           out_q;
  logic                out_valid_q;

  logic                in_accept, load_we;
  logic [ROW_W-1:0]    wr_row, last_row_d;
  entry_t              wr_entry;
  logic                issue;
  scan_tag_t           issue_tag;

  scan_tag_t           tag_q [PIPE];
  logic [ROW_W-1:0]    tag_row_q [PIPE];

  logic [DIST_W-1:0]   lane_dist [LANES];
  logic [LABEL_W-1:0]  lane_label [LANES];
  out_word_t           best;
  logic                best_done;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // Point as carried by the input word.
  always_comb begin
    in_point[0] = in_word_i.coord_0;
    in_point[1] = in_word_i.coord_1;
    in_point[2] = in_word_i.coord_2;
    in_point[3] = in_word_i.coord_3;
  end

  // Load decode; slots beyond the table are dropped.
  assign load_we = in_accept && (in_word_i.opcode == OP_LOAD) &&
                   (int'(in_word_i.entry_index) < MAX_CENTROIDS);
  assign wr_row  = ROW_W'(int'(in_word_i.entry_index) / LANES);
  assign wr_entry.label = in_word_i.entry_label;
  assign wr_entry.point = in_point;

  // Searched entry count, clamped to one..MAX_CENTROIDS, and the last row it reaches.
  always_comb begin
    logic [CMP_W-1:0] act_ext;
    act_ext = CMP_W'(active_q);
    if (act_ext == '0) begin
      count_d = CNT_W'(1);
    end else if (act_ext > CMP_W'(MAX_CENTROIDS)) begin
      count_d = CNT_W'(MAX_CENTROIDS);
    end else begin
      count_d = CNT_W'(act_ext);
    end
    last_row_d = ROW_W'((count_d - CNT_W'(1)) / LANES);
  end

  // Row issue during the scan.
  assign issue           = (state_q == ST_SCAN);
  assign issue_tag.valid = issue;
  assign issue_tag.first = (row_q == '0);
  assign issue_tag.last  = (row_q == last_row_q);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_W'(1);
    end else if (cfg_we_i) begin
      active_q <= cfg_data_i;
    end
  end

  // Scan sequencer with the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      last_row_q  <= '0;
      count_q     <= '0;
      point_q     <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A word taken here is replaced in the same cycle when a scan finishes.
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept && (in_word_i.opcode == OP_CLASSIFY)) begin
            point_q    <= in_point;
            count_q    <= count_d;
            last_row_q <= last_row_d;
            row_q      <= '0;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (row_q == last_row_q) begin
            state_q <= ST_WAIT;
          end else begin
            row_q <= row_q + ROW_W'(1);
          end
        end
        ST_WAIT: begin
          if (best_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= best;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Tag pipeline that matches the lane latency.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < PIPE; s++) begin
        tag_q[s] <= '0;
      end
    end else begin
      tag_q[0] <= issue_tag;
      for (int s = 1; s < PIPE; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  // Row numbers beside the tags.
  always_ff @(posedge clk_i) begin
    tag_row_q[0] <= row_q;
    for (int s = 1; s < PIPE; s++) begin
      tag_row_q[s] <= tag_row_q[s-1];
    end
  end

  // Lanes: entry i sits in bank i mod LANES at row i / LANES.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic lane_we;
    assign lane_we = load_we && ((int'(in_word_i.entry_index) % LANES) == l);

    ncl_lane #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
    ) u_lane (
      .clk_i      (clk_i),
      .wr_en_i    (lane_we),
      .wr_row_i   (wr_row),
      .wr_entry_i (wr_entry),
      .rd_en_i    (issue),
      .rd_row_i   (row_q),
      .point_i    (point_q),
      .dist_o     (lane_dist[l]),
      .label_o    (lane_label[l])
    );
  end

  ncl_merge #(
    .LANES (LANES),
    .ROW_W (ROW_W),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag_q[PIPE-1]),
    .row_i   (tag_row_q[PIPE-1]),
    .count_i (count_q),
    .dist_i  (lane_dist),
    .label_i (lane_label),
    .best_o  (best),
    .done_o  (best_done)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: rtl/ncl_checker.sv
// Port-level checks for the nearest-centroid label block, bound to the top level.
module ncl_checker
  import ncl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed or dropped while stalled");

  // A classify word starts a scan, so the next cycle takes no word.
  a_classify_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_word_i.opcode == OP_CLASSIFY) |=> !in_ready_o)
    else $error("input taken during a scan");

  // A load word completes at once and the block stays ready.
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_word_i.opcode == OP_LOAD) |=> in_ready_o)
    else $error("load word stalled the input");

  // A new result word appears only as the scan ends and the input reopens.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o && !$past(in_ready_o))
    else $error("result word without a finished scan");

endmodule

bind nearest_centroid_label ncl_checker u_ncl_checker (.*);
